[design/sha1_hash_engine_macros.svh]
// assertion macros shared by the checker
`ifndef SHA1_HASH_ENGINE_MACROS_SVH
`define SHA1_HASH_ENGINE_MACROS_SVH

// same-cycle implication
`define SHA1_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHA1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/sha1_pkg.sv]
package sha1_pkg;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_PART = 2'd1;
	localparam logic [1:0] KIND_FULL = 2'd2;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  cnt;
		logic [1:0]  kind;
	} entry_t;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	localparam logic [31:0] PAD_MARK = 32'h80000000;

endpackage

[design/sha1_hash_engine.sv]
// sha-1 engine: message words come in as big-endian beats on push/full, the
// last beat marked and carrying 0 to 4 valid bytes from the top; five digest
// beats (index 0 first) come out on empty/pop. a front stage cleans up the
// last word and queues it in a four-entry fifo; the core collects sixteen
// words, then runs one round per cycle. a block takes 16 word beats plus a
// compression (load, 80 rounds, chain add); the end of a message adds padding
// steps (marker, zero fill, length) and one or two compressions before the
// digest appears. the next message can be accepted while the digest is still
// being popped.
module sha1_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last_word,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_of_digest
);

	// front to queue
	sha1_pkg::entry_t fq_data;
	logic             fq_push;
	logic             fq_full;

	// queue to core
	sha1_pkg::entry_t qc_data;
	logic             qc_pop;
	logic             qc_empty;

	// word cleanup and padding marker
	sha1_front u_front (
		.push       (push),
		.full       (full),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.q_full     (fq_full),
		.q_push     (fq_push),
		.q_data     (fq_data)
	);

	// decouples input beats from compression
	sha1_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.din    (fq_data),
		.full   (fq_full),
		.pop    (qc_pop),
		.dout   (qc_data),
		.empty  (qc_empty)
	);

	// block buffer, padding sequencer, round engine, digest output
	sha1_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (qc_empty),
		.q_data         (qc_data),
		.q_pop          (qc_pop),
		.empty          (empty),
		.pop            (pop),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_of_digest (last_of_digest)
	);

endmodule

[design/sha1_front.sv]
module sha1_front (
	input  logic                push,
	output logic                full,
	input  logic [31:0]         data_word,
	input  logic [2:0]          byte_count,
	input  logic                last_word,
	input  logic                q_full,
	output logic                q_push,
	output sha1_pkg::entry_t    q_data
);

	logic [2:0]  cnt;
	logic [31:0] keep;

	assign full   = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		// saturate the count of a last word, other words carry four bytes
		if (!last_word || byte_count > 3'd4) begin
			cnt = 3'd4;
		end else begin
			cnt = byte_count;
		end
		unique case (cnt)
			3'd0:    keep = 32'h00000000;
			3'd1:    keep = 32'hFF000000;
			3'd2:    keep = 32'hFFFF0000;
			3'd3:    keep = 32'hFFFFFF00;
			default: keep = 32'hFFFFFFFF;
		endcase
		q_data.cnt = cnt;
		if (!last_word) begin
			q_data.kind = sha1_pkg::KIND_DATA;
			q_data.word = data_word;
		end else if (cnt == 3'd4) begin
			q_data.kind = sha1_pkg::KIND_FULL;
			q_data.word = data_word;
		end else begin
			// marker byte goes to the first invalid byte
			q_data.kind = sha1_pkg::KIND_PART;
			q_data.word = (data_word & keep) | (sha1_pkg::PAD_MARK >> {cnt[1:0], 3'b000});
		end
	end

endmodule

[design/sha1_fifo.sv]
module sha1_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sha1_pkg::entry_t din,
	output logic             full,
	input  logic             pop,
	output sha1_pkg::entry_t dout,
	output logic             empty
);

	sha1_pkg::entry_t              mem_q [sha1_pkg::Q_DEPTH];
	logic [sha1_pkg::Q_AW-1:0]     wr_q;
	logic [sha1_pkg::Q_AW-1:0]     rd_q;
	logic [sha1_pkg::Q_CW-1:0]     cnt_q;
	logic                          do_push;
	logic                          do_pop;

	assign full    = cnt_q == sha1_pkg::Q_CW'(sha1_pkg::Q_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/sha1_core.sv]
module sha1_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  sha1_pkg::entry_t q_data,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_of_digest
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MARK = 4'd1;
	localparam logic [3:0] ST_PAD  = 4'd2;
	localparam logic [3:0] ST_CLR  = 4'd3;
	localparam logic [3:0] ST_LEN  = 4'd4;
	localparam logic [3:0] ST_OUT  = 4'd5;
	localparam logic [3:0] ST_LOAD = 4'd6;
	localparam logic [3:0] ST_RUN  = 4'd7;
	localparam logic [3:0] ST_FIN  = 4'd8;

	logic [3:0]  state_q;
	logic [3:0]  ret_q;
	logic [4:0]  idx_q;
	logic [60:0] msg_q;
	logic [6:0]  t_q;
	logic [31:0] chain_q [5];
	logic [31:0] buf_q   [16];
	logic [31:0] sched_q [16];
	logic [31:0] var_q   [5];
	logic [31:0] out_q   [5];
	logic [2:0]  pos_q;
	logic        ovalid_q;

	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] tmp;
	logic [31:0] wnew;
	logic        take;

	assign take  = (state_q == ST_IDLE) && !q_empty;
	assign q_pop = take;

	assign empty          = !ovalid_q;
	assign digest_word    = out_q[pos_q];
	assign word_index     = pos_q;
	assign last_of_digest = pos_q == 3'd4;

	always_comb begin
		priority if (t_q < 7'd20) begin
			f = var_q[3] ^ (var_q[1] & (var_q[2] ^ var_q[3]));
			k = sha1_pkg::K0;
		end else if (t_q < 7'd40) begin
			f = var_q[1] ^ var_q[2] ^ var_q[3];
			k = sha1_pkg::K1;
		end else if (t_q < 7'd60) begin
			f = (var_q[1] & var_q[2]) | ((var_q[1] | var_q[2]) & var_q[3]);
			k = sha1_pkg::K2;
		end else begin
			f = var_q[1] ^ var_q[2] ^ var_q[3];
			k = sha1_pkg::K3;
		end
		tmp  = {var_q[0][26:0], var_q[0][31:27]} + f + var_q[4] + k + sched_q[0];
		wnew = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
		wnew = {wnew[30:0], wnew[31]};
	end

	// block buffer and working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					buf_q[idx_q[3:0]] <= q_data.word;
				end
			end
			ST_MARK: buf_q[idx_q[3:0]] <= sha1_pkg::PAD_MARK;
			ST_PAD: begin
				for (int i = 0; i < 16; i++) begin
					if (5'(i) >= idx_q) begin
						buf_q[i] <= '0;
					end
				end
			end
			ST_CLR: begin
				for (int i = 0; i < 16; i++) begin
					buf_q[i] <= '0;
				end
			end
			ST_LEN: begin
				buf_q[14] <= msg_q[60:29];
				buf_q[15] <= {msg_q[28:0], 3'b000};
			end
			ST_LOAD: begin
				for (int i = 0; i < 16; i++) begin
					sched_q[i] <= buf_q[i];
				end
				for (int i = 0; i < 5; i++) begin
					var_q[i] <= chain_q[i];
				end
			end
			ST_RUN: begin
				for (int i = 0; i < 15; i++) begin
					sched_q[i] <= sched_q[i+1];
				end
				sched_q[15] <= wnew;
				var_q[4] <= var_q[3];
				var_q[3] <= var_q[2];
				var_q[2] <= {var_q[1][1:0], var_q[1][31:2]};
				var_q[1] <= var_q[0];
				var_q[0] <= tmp;
			end
			ST_OUT: begin
				if (!ovalid_q) begin
					for (int i = 0; i < 5; i++) begin
						out_q[i] <= chain_q[i];
					end
				end
			end
			default: ;
		endcase
	end

	// control, chaining value and digest beat counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ret_q      <= ST_IDLE;
			idx_q      <= '0;
			msg_q      <= '0;
			t_q        <= '0;
			pos_q      <= '0;
			ovalid_q   <= 1'b0;
			chain_q[0] <= sha1_pkg::H0;
			chain_q[1] <= sha1_pkg::H1;
			chain_q[2] <= sha1_pkg::H2;
			chain_q[3] <= sha1_pkg::H3;
			chain_q[4] <= sha1_pkg::H4;
		end else begin
			if (ovalid_q && pop) begin
				if (pos_q == 3'd4) begin
					ovalid_q <= 1'b0;
				end
				pos_q <= pos_q + 3'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						msg_q <= msg_q + 61'(q_data.cnt);
						unique case (q_data.kind)
							sha1_pkg::KIND_PART: begin
								idx_q   <= idx_q + 5'd1;
								state_q <= ST_PAD;
							end
							sha1_pkg::KIND_FULL: begin
								if (idx_q == 5'd15) begin
									idx_q   <= '0;
									ret_q   <= ST_MARK;
									state_q <= ST_LOAD;
								end else begin
									idx_q   <= idx_q + 5'd1;
									state_q <= ST_MARK;
								end
							end
							default: begin
								if (idx_q == 5'd15) begin
									idx_q   <= '0;
									ret_q   <= ST_IDLE;
									state_q <= ST_LOAD;
								end else begin
									idx_q <= idx_q + 5'd1;
								end
							end
						endcase
					end
				end
				ST_MARK: begin
					idx_q   <= idx_q + 5'd1;
					state_q <= ST_PAD;
				end
				ST_PAD: begin
					// no room for the length, it goes in an extra block
					if (idx_q >= 5'd15) begin
						ret_q   <= ST_CLR;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_LEN;
					end
				end
				ST_CLR: state_q <= ST_LEN;
				ST_LEN: begin
					ret_q   <= ST_OUT;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					t_q     <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					t_q <= t_q + 7'd1;
					if (t_q == 7'd79) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					for (int i = 0; i < 5; i++) begin
						chain_q[i] <= chain_q[i] + var_q[i];
					end
					state_q <= ret_q;
				end
				ST_OUT: begin
					if (!ovalid_q) begin
						ovalid_q   <= 1'b1;
						pos_q      <= '0;
						idx_q      <= '0;
						msg_q      <= '0;
						chain_q[0] <= sha1_pkg::H0;
						chain_q[1] <= sha1_pkg::H1;
						chain_q[2] <= sha1_pkg::H2;
						chain_q[3] <= sha1_pkg::H3;
						chain_q[4] <= sha1_pkg::H4;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[design/sha1_checker.sv]
`include "sha1_hash_engine_macros.svh"

module sha1_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [2:0] word_index,
	input logic       last_of_digest
);

	`SHA1_ASSERT_NOW(a_last_flag, clk, arst_n, !empty, last_of_digest == (word_index == 3'd4), "last flag off index")
	`SHA1_ASSERT_NEXT(a_index_step, clk, arst_n, !empty && pop && !last_of_digest, !empty && word_index == $past(word_index) + 3'd1, "digest beat skipped")
	`SHA1_ASSERT_NEXT(a_gap_after, clk, arst_n, !empty && pop && last_of_digest, empty, "digest follows without gap")
	`SHA1_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(word_index), "stalled beat changed")

endmodule

bind sha1_hash_engine sha1_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.word_index     (word_index),
	.last_of_digest (last_of_digest)
);
